FILE: src/gam_pkg.sv
// Shared types and constants of the greedy assignment matcher.
`default_nettype none
package gam_pkg;

  localparam int FIELD_W    = 5;
  localparam int SIZE_W     = 6;
  localparam int COST_W     = 32;
  localparam int SUM_W      = 37;
  localparam int MAX_OUT    = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef struct packed {
    logic load;
    logic run_init;
    logic scan_step;
    logic commit;
    logic emit_step;
  } gam_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pairs_last;
    logic emit_last;
  } gam_status_t;

endpackage
`default_nettype wire

FILE: src/gam_ctrl.sv
// Controller state machine sequencing load, search rounds and result beats.
`default_nettype none
module gam_ctrl
  import gam_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        last_entry,
  input  wire gam_status_t status,
  output gam_cmd_t         cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    FLUSH,
    COMMIT,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      IDLE: begin
        cmd.load     = start;
        cmd.run_init = start && last_entry;
        if (start && last_entry) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = FLUSH;
        end
      end
      FLUSH: begin
        state_next = COMMIT;
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        state_next = status.pairs_last ? EMIT : SCAN;
      end
      EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_last) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule
`default_nettype wire

FILE: src/gam_datapath.sv
// Datapath: cost memory, minimum search, match flags, partner store and result registers.
`default_nettype none
module gam_datapath
  import gam_pkg::*;
#(
  parameter int MAX_SIZE = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire gam_cmd_t                 cmd,
  output gam_status_t                   status,
  input  wire logic                     cfg_valid,
  input  wire logic [SIZE_W-1:0]        cfg_data,
  input  wire logic [FIELD_W-1:0]       row_index,
  input  wire logic [FIELD_W-1:0]       col_index,
  input  wire logic signed [COST_W-1:0] cost_value,
  output logic                          result_valid,
  output logic [FIELD_W-1:0]            out_row,
  output logic [FIELD_W-1:0]            out_col,
  output logic signed [SUM_W-1:0]       total_cost,
  output logic                          last_result
);

  localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W     = $clog2(MAX_SIZE + 1);
  localparam int MEM_DEPTH = 1 << (2 * IDX_W);

  logic signed [COST_W-1:0] cost_mem [MEM_DEPTH];
  logic [IDX_W-1:0]         partner_mem [MAX_SIZE];

  logic [SIZE_W-1:0]        matrix_size;
  logic [CNT_W-1:0]         n_act;
  logic [CNT_W-1:0]         n_run;
  logic [CNT_W-1:0]         pairs;
  logic [IDX_W-1:0]         scan_r;
  logic [IDX_W-1:0]         scan_c;
  logic [IDX_W-1:0]         rd_r;
  logic [IDX_W-1:0]         rd_c;
  logic                     rd_valid;
  logic signed [COST_W-1:0] rd_data;
  logic                     found;
  logic signed [COST_W-1:0] best;
  logic [IDX_W-1:0]         best_r;
  logic [IDX_W-1:0]         best_c;
  logic [MAX_SIZE-1:0]      row_matched;
  logic [MAX_SIZE-1:0]      col_taken;
  logic signed [SUM_W-1:0]  sum;
  logic [IDX_W-1:0]         emit_idx;
  logic                     in_range;
  logic                     cand_ok;
  logic                     c_end;
  logic                     emit_fin;

  always_comb begin
    if (matrix_size == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(matrix_size) > 32'(MAX_SIZE)) begin
      n_act = CNT_W'(MAX_SIZE);
    end else begin
      n_act = CNT_W'(matrix_size);
    end
  end

  assign in_range = (32'(row_index) < 32'(MAX_SIZE)) && (32'(col_index) < 32'(MAX_SIZE));
  assign c_end    = (CNT_W'(scan_c) == n_run - CNT_W'(1));
  assign cand_ok  = rd_valid && !row_matched[rd_r] && !col_taken[rd_c];
  assign emit_fin = (CNT_W'(emit_idx) == n_run - CNT_W'(1)) ||
                    (32'(emit_idx) == 32'(MAX_OUT - 1));

  always_comb begin
    status.scan_last  = c_end && (CNT_W'(scan_r) == n_run - CNT_W'(1));
    status.pairs_last = (pairs == n_run - CNT_W'(1));
    status.emit_last  = emit_fin;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      cost_mem[{IDX_W'(row_index), IDX_W'(col_index)}] <= cost_value;
    end
    if (cmd.scan_step) begin
      rd_data <= cost_mem[{scan_r, scan_c}];
    end
    if (cmd.commit) begin
      partner_mem[best_r] <= best_c;
    end
    if (cmd.emit_step) begin
      out_col <= FIELD_W'(partner_mem[emit_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size  <= SIZE_RESET;
      n_run        <= CNT_W'(MAX_SIZE);
      pairs        <= '0;
      scan_r       <= '0;
      scan_c       <= '0;
      rd_r         <= '0;
      rd_c         <= '0;
      rd_valid     <= 1'b0;
      found        <= 1'b0;
      best         <= '0;
      best_r       <= '0;
      best_c       <= '0;
      row_matched  <= '0;
      col_taken    <= '0;
      sum          <= '0;
      emit_idx     <= '0;
      result_valid <= 1'b0;
      out_row      <= '0;
      total_cost   <= '0;
      last_result  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        matrix_size <= cfg_data;
      end

      rd_valid <= cmd.scan_step;
      if (cmd.scan_step) begin
        rd_r <= scan_r;
        rd_c <= scan_c;
        if (c_end) begin
          scan_c <= '0;
          scan_r <= scan_r + IDX_W'(1);
        end else begin
          scan_c <= scan_c + IDX_W'(1);
        end
      end

      if (cmd.run_init || cmd.commit) begin
        found <= 1'b0;
      end else if (cand_ok && (!found || (rd_data < best))) begin
        found  <= 1'b1;
        best   <= rd_data;
        best_r <= rd_r;
        best_c <= rd_c;
      end

      if (cmd.run_init) begin
        n_run       <= n_act;
        pairs       <= '0;
        sum         <= '0;
        scan_r      <= '0;
        scan_c      <= '0;
        emit_idx    <= '0;
        row_matched <= '0;
        col_taken   <= '0;
      end

      if (cmd.commit) begin
        row_matched[best_r] <= 1'b1;
        col_taken[best_c]   <= 1'b1;
        sum                 <= sum + SUM_W'(best);
        pairs               <= pairs + CNT_W'(1);
        scan_r              <= '0;
        scan_c              <= '0;
      end

      result_valid <= cmd.emit_step;
      if (cmd.emit_step) begin
        out_row     <= FIELD_W'(emit_idx);
        last_result <= emit_fin;
        total_cost  <= emit_fin ? sum : '0;
        emit_idx    <= emit_idx + IDX_W'(1);
      end
    end
  end

  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> found)
    else $error("commit without a candidate");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!row_matched[best_r] && !col_taken[best_c]))
    else $error("commit on a taken row or column");

  a_pairs_bound: assert property (@(posedge clk) disable iff (rst)
    pairs <= n_run)
    else $error("more pairs than rows");

  a_total_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> (total_cost == '0))
    else $error("total on a non-final beat");

endmodule
`default_nettype wire

FILE: src/greedy_assignment_matcher_top.sv
// Top level of the greedy assignment matcher.
// Each cost entry loads while start is high and busy is low. The entry
// marked last starts a run: n rounds, each scanning the n-by-n active window
// through the single read port of the cost memory at one entry per cycle and
// then passing a flush state and a commit state, followed by min(n,32)
// result beats on consecutive cycles. Results are one-cycle strobes and cannot
// be held off. The configuration channel is always ready; write it only while
// the block is idle.
`default_nettype none
module greedy_assignment_matcher_top
  import gam_pkg::*;
#(
  parameter int MAX_SIZE = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [FIELD_W-1:0]       row_index,
  input  wire logic [FIELD_W-1:0]       col_index,
  input  wire logic signed [COST_W-1:0] cost_value,
  input  wire logic                     last_entry,
  output logic                          result_valid,
  output logic [FIELD_W-1:0]            out_row,
  output logic [FIELD_W-1:0]            out_col,
  output logic signed [SUM_W-1:0]       total_cost,
  output logic                          last_result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [SIZE_W-1:0]        cfg_data
);

  gam_cmd_t    cmd;
  gam_status_t status;

  assign cfg_ready = 1'b1;

  gam_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_entry (last_entry),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  gam_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .row_index    (row_index),
    .col_index    (col_index),
    .cost_value   (cost_value),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .total_cost   (total_cost),
    .last_result  (last_result)
  );

endmodule
`default_nettype wire
